// File: rtl/cdtab_pkg.sv
// ----------------------------------------------------------------------------
// cdtab_pkg
// Shared types and constants for the countdown timer and alarm bank: item
// layouts, per-slot record, action codes and sequencer states.
// ----------------------------------------------------------------------------
package cdtab_pkg;

  // default slot counts
  localparam int TimerSlotsDefault = 5;
  localparam int AlarmSlotsDefault = 5;

  // slots shown in the status masks
  localparam int MaskBits = 5;

  // time field limits
  localparam logic [6:0] FieldMax  = 7'd99;
  localparam logic [6:0] WrapValue = 7'd59;

  // configuration register
  localparam logic [7:0] HoldReset = 8'd7;
  localparam int         ApbAddrW  = 3;
  localparam logic       HoldIdx   = 1'b0;

  // action codes
  typedef enum logic [1:0] {
    ACT_TICK      = 2'd0,
    ACT_SET_TIMER = 2'd1,
    ACT_SET_ALARM = 2'd2,
    ACT_READ      = 2'd3
  } action_e;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_READ,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [1:0] action;
    logic [6:0] set_hours;
    logic [6:0] set_minutes;
    logic [6:0] set_seconds;
    logic [4:0] now_hour;
    logic [5:0] now_minute;
    logic [5:0] now_second;
    logic       slot_kind;
    logic [2:0] slot_number;
  } in_item_t;

  typedef struct packed {
    logic       accepted;
    logic [2:0] slot_used;
    logic       ring;
    logic [4:0] timer_done_mask;
    logic [4:0] alarm_done_mask;
    logic [4:0] timer_active_mask;
    logic [4:0] alarm_active_mask;
    logic [6:0] read_hours;
    logic [6:0] read_minutes;
    logic [6:0] read_seconds;
  } out_item_t;

  // one slot as kept in the memory
  typedef struct packed {
    logic [6:0] hours;
    logic [6:0] minutes;
    logic [6:0] seconds;
    logic [7:0] age;
  } slot_rec_t;

  // per-slot status kept in flops
  typedef struct packed {
    logic active;
    logic done;
  } slot_flags_t;

  // time of day carried by a tick
  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } now_t;

  // saturate a set field at 99
  function automatic logic [6:0] sat99(input logic [6:0] v);
    return (v > FieldMax) ? FieldMax : v;
  endfunction

endpackage

// File: rtl/cdtab_ram.sv
// ----------------------------------------------------------------------------
// cdtab_ram
// Generic single-clock RAM, one write port and one read port, read data
// registered.
// ----------------------------------------------------------------------------
module cdtab_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// File: rtl/cdtab_slot_upd.sv
// ----------------------------------------------------------------------------
// cdtab_slot_upd
// Tick update of one slot: countdown with borrow for a timer, time-of-day
// match for an alarm, and ageing and release of a done slot.
// ----------------------------------------------------------------------------
module cdtab_slot_upd
  import cdtab_pkg::*;
(
  input  slot_rec_t   cur_rec_i,
  input  slot_flags_t cur_flg_i,
  input  logic        is_alarm_i,
  input  logic [7:0]  hold_i,
  input  now_t        now_i,
  output slot_rec_t   nxt_rec_o,
  output slot_flags_t nxt_flg_o
);

  logic [8:0] age_inc;
  logic       expire;
  logic       at_zero;
  logic       match;

  assign age_inc = {1'b0, cur_rec_i.age} + 9'd1;
  assign expire  = age_inc > {1'b0, hold_i};
  assign at_zero = (cur_rec_i.hours == '0) && (cur_rec_i.minutes == '0) &&
                   (cur_rec_i.seconds == '0);
  assign match   = (cur_rec_i.hours == {2'b00, now_i.hour}) &&
                   (cur_rec_i.minutes == {1'b0, now_i.minute}) &&
                   (cur_rec_i.seconds == {1'b0, now_i.second});

  // next record and status
  always_comb begin
    nxt_rec_o = cur_rec_i;
    nxt_flg_o = cur_flg_i;
    if (cur_flg_i.active) begin
      if (cur_flg_i.done) begin
        // ringing slot ages, freed once past the hold time
        if (expire) begin
          nxt_flg_o.active = 1'b0;
          nxt_flg_o.done   = 1'b0;
          nxt_rec_o.age    = '0;
        end else begin
          nxt_rec_o.age = age_inc[7:0];
        end
      end else if (is_alarm_i) begin
        if (match) begin
          nxt_flg_o.done = 1'b1;
          nxt_rec_o.age  = '0;
        end
      end else if (at_zero) begin
        nxt_flg_o.done = 1'b1;
        nxt_rec_o.age  = '0;
      end else if (cur_rec_i.seconds != '0) begin
        nxt_rec_o.seconds = cur_rec_i.seconds - 7'd1;
      end else if (cur_rec_i.minutes != '0) begin
        nxt_rec_o.minutes = cur_rec_i.minutes - 7'd1;
        nxt_rec_o.seconds = WrapValue;
      end else begin
        nxt_rec_o.hours   = cur_rec_i.hours - 7'd1;
        nxt_rec_o.minutes = WrapValue;
        nxt_rec_o.seconds = WrapValue;
      end
    end
  end

endmodule

// File: rtl/countdown_timer_alarm_bank.sv
// Set items go from IDLE straight to FINISH, reads pass through READ, and ticks
// walk every slot in WALK before FINISH loads the registered result.
// Throughput: one item at a time; a tick holds off the next transfer while it
// walks the slots, set by the single read and write port of the slot memory.
// Reset: all slots inactive and reading zero, hold_seconds 7, no result held.
// ----------------------------------------------------------------------------
// countdown_timer_alarm_bank
// Bank of hours/minutes/seconds countdown timers and time-of-day alarms.
// Slot times and ages sit in one memory; a sequencer walks it on each tick.
// ----------------------------------------------------------------------------
module countdown_timer_alarm_bank
  import cdtab_pkg::*;
#(
  parameter int TIMER_SLOTS = TimerSlotsDefault,
  parameter int ALARM_SLOTS = AlarmSlotsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // item input
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_data_i,
  // result output
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_item_t           out_data_o,
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int N  = TIMER_SLOTS + ALARM_SLOTS;
  localparam int AW = $clog2(N);
  localparam int IW = $clog2(N + 1);
  localparam int RW = $bits(slot_rec_t);

  // configuration register
  logic [7:0] hold_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == HoldIdx);
  assign prdata = (paddr[2] == HoldIdx) ? {24'd0, hold_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= HoldReset;
    end else if (cfg_wr) begin
      hold_q <= pwdata[7:0];
    end
  end

  // sequencer and per-slot status
  state_e         state_q, state_d;
  logic [N-1:0]   act_q, done_q, wr_q;
  logic [IW-1:0]  idx_q, idx_d;
  logic           proc_vld_q, proc_vld_d;
  logic [AW-1:0]  proc_addr_q;
  now_t           now_q;
  logic [AW-1:0]  rd_addr_q;
  logic           rd_ok_q;

  // item results
  logic           acc_q;
  logic [2:0]     used_q;
  logic [6:0]     rh_q, rm_q, rs_q;

  // output register
  logic           out_vld_q;
  out_item_t      out_q;

  logic           in_xfer;
  logic           out_load;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;
  assign out_load    = (state_q == ST_FINISH) && (!out_vld_q || !out_stall_i);

  // memory ports
  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  slot_rec_t       ram_wdata, ram_rdata;

  cdtab_ram #(
    .WIDTH (RW),
    .DEPTH (N)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // tick update of the slot in flight
  slot_rec_t   cur_rec, nxt_rec;
  slot_flags_t cur_flg, nxt_flg;
  logic        cur_alarm;

  assign cur_rec       = wr_q[proc_addr_q] ? ram_rdata : '0;
  assign cur_flg.active = act_q[proc_addr_q];
  assign cur_flg.done   = done_q[proc_addr_q];
  assign cur_alarm     = ({1'b0, proc_addr_q} >= (AW+1)'(TIMER_SLOTS));

  cdtab_slot_upd u_upd (
    .cur_rec_i  (cur_rec),
    .cur_flg_i  (cur_flg),
    .is_alarm_i (cur_alarm),
    .hold_i     (hold_q),
    .now_i      (now_q),
    .nxt_rec_o  (nxt_rec),
    .nxt_flg_o  (nxt_flg)
  );

  // first free slot of each kind
  logic [AW-1:0] free_t, free_a;
  logic          found_t, found_a;

  always_comb begin
    free_t  = '0;
    found_t = 1'b0;
    for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
      if (!act_q[i]) begin
        free_t  = AW'(i);
        found_t = 1'b1;
      end
    end
    free_a  = '0;
    found_a = 1'b0;
    for (int j = ALARM_SLOTS - 1; j >= 0; j--) begin
      if (!act_q[TIMER_SLOTS + j]) begin
        free_a  = AW'(j);
        found_a = 1'b1;
      end
    end
  end

  // set and read decode of the incoming item
  logic          is_set_t, is_set_a, is_rd, set_hit;
  logic [AW-1:0] set_addr;
  logic          rd_ok;
  logic [AW-1:0] rd_addr;

  assign is_set_t = in_xfer && (in_data_i.action == ACT_SET_TIMER);
  assign is_set_a = in_xfer && (in_data_i.action == ACT_SET_ALARM);
  assign is_rd    = in_xfer && (in_data_i.action == ACT_READ);
  assign set_hit  = (is_set_t && found_t) || (is_set_a && found_a);
  assign set_addr = is_set_a ? (AW'(TIMER_SLOTS) + free_a) : free_t;

  always_comb begin
    rd_ok   = 1'b0;
    rd_addr = '0;
    if (!in_data_i.slot_kind) begin
      if (int'(in_data_i.slot_number) < TIMER_SLOTS) begin
        rd_ok   = 1'b1;
        rd_addr = AW'(in_data_i.slot_number);
      end
    end else if (int'(in_data_i.slot_number) < ALARM_SLOTS) begin
      rd_ok   = 1'b1;
      rd_addr = AW'(TIMER_SLOTS) + AW'(in_data_i.slot_number);
    end
  end

  // memory access selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = proc_addr_q;
    ram_wdata = nxt_rec;
    ram_re    = 1'b0;
    ram_raddr = idx_q[AW-1:0];
    if (state_q == ST_IDLE) begin
      ram_we    = set_hit;
      ram_waddr = set_addr;
      ram_wdata = '{hours:   sat99(in_data_i.set_hours),
                    minutes: sat99(in_data_i.set_minutes),
                    seconds: sat99(in_data_i.set_seconds),
                    age:     8'd0};
      ram_re    = is_rd;
      ram_raddr = rd_addr;
    end else if (state_q == ST_WALK) begin
      ram_we = proc_vld_q && cur_flg.active;
      ram_re = (idx_q < IW'(N));
    end
  end

  // next state and walk control
  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    proc_vld_d = 1'b0;
    case (state_q)
      ST_IDLE: begin
        idx_d = '0;
        if (in_xfer) begin
          case (in_data_i.action)
            ACT_TICK: state_d = ST_WALK;
            ACT_READ: state_d = ST_READ;
            default:  state_d = ST_FINISH;
          endcase
        end
      end
      ST_WALK: begin
        if (idx_q < IW'(N)) begin
          idx_d      = idx_q + IW'(1);
          proc_vld_d = 1'b1;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_READ: state_d = ST_FINISH;
      ST_FINISH: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      idx_q      <= '0;
      proc_vld_q <= 1'b0;
      act_q      <= '0;
      done_q     <= '0;
      wr_q       <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      proc_vld_q <= proc_vld_d;
      if (ram_we) begin
        wr_q[ram_waddr] <= 1'b1;
      end
      // status of a newly set slot
      if (state_q == ST_IDLE && set_hit) begin
        act_q[set_addr]  <= 1'b1;
        done_q[set_addr] <= 1'b0;
      end
      // status of the slot updated by the walk
      if (state_q == ST_WALK && proc_vld_q) begin
        act_q[proc_addr_q]  <= nxt_flg.active;
        done_q[proc_addr_q] <= nxt_flg.done;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_vld_q && !out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // item payload registers
  always_ff @(posedge clk_i) begin
    proc_addr_q <= idx_q[AW-1:0];
    if (in_xfer) begin
      now_q     <= '{hour:   in_data_i.now_hour,
                     minute: in_data_i.now_minute,
                     second: in_data_i.now_second};
      rd_addr_q <= rd_addr;
      rd_ok_q   <= rd_ok;
      acc_q     <= set_hit;
      used_q    <= set_hit ? (is_set_a ? 3'(free_a) : 3'(free_t)) : 3'd0;
      rh_q      <= '0;
      rm_q      <= '0;
      rs_q      <= '0;
    end
    // read data comes back in the cycle after the transfer
    if (state_q == ST_READ && rd_ok_q && wr_q[rd_addr_q]) begin
      rh_q <= ram_rdata.hours;
      rm_q <= ram_rdata.minutes;
      rs_q <= ram_rdata.seconds;
    end
  end

  // status masks after the item
  logic [MaskBits-1:0] tam, tdm, aam, adm;
  logic                ring;

  always_comb begin
    tam  = '0;
    tdm  = '0;
    aam  = '0;
    adm  = '0;
    ring = |(act_q & done_q);
    for (int i = 0; i < MaskBits; i++) begin
      if (i < TIMER_SLOTS) begin
        tam[i] = act_q[i];
        tdm[i] = act_q[i] && done_q[i];
      end
      if (i < ALARM_SLOTS) begin
        aam[i] = act_q[TIMER_SLOTS + i];
        adm[i] = act_q[TIMER_SLOTS + i] && done_q[TIMER_SLOTS + i];
      end
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= '{accepted:          acc_q,
                 slot_used:         used_q,
                 ring:              ring,
                 timer_done_mask:   tdm,
                 alarm_done_mask:   adm,
                 timer_active_mask: tam,
                 alarm_active_mask: aam,
                 read_hours:        rh_q,
                 read_minutes:      rm_q,
                 read_seconds:      rs_q};
    end
  end

endmodule

// File: rtl/cdtab_checker.sv
// ----------------------------------------------------------------------------
// cdtab_checker
// Port-level checks for the countdown timer and alarm bank, bound to the top.
// ----------------------------------------------------------------------------
module cdtab_checker
  import cdtab_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_data_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // the block is busy in the cycle after an input transfer
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while an item is in work");

  // a dropped or non-set item reports slot zero
  a_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.accepted |-> out_data_o.slot_used == 3'd0)
    else $error("slot index without a filled slot");

  // a done slot must also be active
  a_done_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      ((out_data_o.timer_done_mask & ~out_data_o.timer_active_mask) == '0) &&
      ((out_data_o.alarm_done_mask & ~out_data_o.alarm_active_mask) == '0))
    else $error("done slot not active");

  // any done slot rings
  a_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((out_data_o.timer_done_mask != '0) ||
                    (out_data_o.alarm_done_mask != '0)) |-> out_data_o.ring)
    else $error("done slot without ring");

endmodule

bind countdown_timer_alarm_bank cdtab_checker u_cdtab_checker (.*);

// File: tb/tb_countdown_timer_alarm_bank.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_countdown_timer_alarm_bank
// Self-checking bench for the countdown timer and alarm bank. Items go in
// through the valid/stall port with random gaps and the results are checked
// field by field against a bank model kept here. The hold register is moved
// between phases, its extremes included.
// ----------------------------------------------------------------------------
module tb_countdown_timer_alarm_bank
  import cdtab_pkg::*;
;

  localparam int NumTimers = TimerSlotsDefault;
  localparam int NumAlarms = AlarmSlotsDefault;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i;
  logic                in_stall_o;
  in_item_t            in_data_i;
  logic                out_valid_o;
  logic                out_stall_i;
  out_item_t           out_data_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  // bank model state
  logic [6:0] tmr_h    [NumTimers] = '{default: '0};
  logic [6:0] tmr_m    [NumTimers] = '{default: '0};
  logic [6:0] tmr_s    [NumTimers] = '{default: '0};
  logic       tmr_act  [NumTimers] = '{default: '0};
  logic       tmr_done [NumTimers] = '{default: '0};
  logic [7:0] tmr_age  [NumTimers] = '{default: '0};
  logic [6:0] alm_h    [NumAlarms] = '{default: '0};
  logic [6:0] alm_m    [NumAlarms] = '{default: '0};
  logic [6:0] alm_s    [NumAlarms] = '{default: '0};
  logic       alm_act  [NumAlarms] = '{default: '0};
  logic       alm_done [NumAlarms] = '{default: '0};
  logic [7:0] alm_age  [NumAlarms] = '{default: '0};
  logic [7:0] hold_model = HoldReset;

  out_item_t pending_results [$];
  int        mismatch_count = 0;
  bit        in_idle_on = 1'b1;
  bit        out_idle_on = 1'b1;

  // time of day carried by well-formed ticks
  int tod_h = 23;
  int tod_m = 59;
  int tod_s = 30;

  countdown_timer_alarm_bank dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // bank model
  // ---------------------------------------------------------------------------

  function automatic logic [6:0] clamp_field(logic [6:0] v);
    return (v > FieldMax) ? FieldMax : v;
  endfunction

  // a done slot is released once its next age would pass the hold time
  function automatic bit hold_expired(logic [7:0] age);
    return ({1'b0, age} + 9'd1) > {1'b0, hold_model};
  endfunction

  function automatic out_item_t bank_step(in_item_t it);
    out_item_t  r;
    logic [6:0] h;
    logic [6:0] m;
    logic [6:0] s;
    r = '0;
    h = clamp_field(it.set_hours);
    m = clamp_field(it.set_minutes);
    s = clamp_field(it.set_seconds);
    case (it.action)
      ACT_TICK: begin
        // timers count down with borrow, or age once done
        for (int k = 0; k < NumTimers; k++) begin
          if (!tmr_act[k]) continue;
          if (tmr_done[k]) begin
            if (hold_expired(tmr_age[k])) begin
              tmr_act[k]  = 1'b0;
              tmr_done[k] = 1'b0;
              tmr_age[k]  = '0;
            end else begin
              tmr_age[k] = tmr_age[k] + 8'd1;
            end
          end else if (tmr_h[k] == 0 && tmr_m[k] == 0 && tmr_s[k] == 0) begin
            tmr_done[k] = 1'b1;
            tmr_age[k]  = '0;
          end else if (tmr_s[k] != 0) begin
            tmr_s[k] = tmr_s[k] - 7'd1;
          end else if (tmr_m[k] != 0) begin
            tmr_m[k] = tmr_m[k] - 7'd1;
            tmr_s[k] = WrapValue;
          end else begin
            tmr_h[k] = tmr_h[k] - 7'd1;
            tmr_m[k] = WrapValue;
            tmr_s[k] = WrapValue;
          end
        end
        // alarms match the carried time of day, or age once done
        for (int k = 0; k < NumAlarms; k++) begin
          if (!alm_act[k]) continue;
          if (alm_done[k]) begin
            if (hold_expired(alm_age[k])) begin
              alm_act[k]  = 1'b0;
              alm_done[k] = 1'b0;
              alm_age[k]  = '0;
            end else begin
              alm_age[k] = alm_age[k] + 8'd1;
            end
          end else if (alm_h[k] == {2'b00, it.now_hour} &&
                       alm_m[k] == {1'b0, it.now_minute} &&
                       alm_s[k] == {1'b0, it.now_second}) begin
            alm_done[k] = 1'b1;
            alm_age[k]  = '0;
          end
        end
      end
      ACT_SET_TIMER: begin
        for (int k = 0; k < NumTimers; k++) begin
          if (!tmr_act[k]) begin
            tmr_h[k]    = h;
            tmr_m[k]    = m;
            tmr_s[k]    = s;
            tmr_act[k]  = 1'b1;
            tmr_done[k] = 1'b0;
            tmr_age[k]  = '0;
            r.accepted  = 1'b1;
            r.slot_used = 3'(k);
            break;
          end
        end
      end
      ACT_SET_ALARM: begin
        for (int k = 0; k < NumAlarms; k++) begin
          if (!alm_act[k]) begin
            alm_h[k]    = h;
            alm_m[k]    = m;
            alm_s[k]    = s;
            alm_act[k]  = 1'b1;
            alm_done[k] = 1'b0;
            alm_age[k]  = '0;
            r.accepted  = 1'b1;
            r.slot_used = 3'(k);
            break;
          end
        end
      end
      default: begin
        // out of range slots read as zero
        if (!it.slot_kind && it.slot_number < NumTimers) begin
          r.read_hours   = tmr_h[it.slot_number];
          r.read_minutes = tmr_m[it.slot_number];
          r.read_seconds = tmr_s[it.slot_number];
        end else if (it.slot_kind && it.slot_number < NumAlarms) begin
          r.read_hours   = alm_h[it.slot_number];
          r.read_minutes = alm_m[it.slot_number];
          r.read_seconds = alm_s[it.slot_number];
        end
      end
    endcase
    // status after the item
    for (int k = 0; k < NumTimers; k++) begin
      if (tmr_act[k] && tmr_done[k]) r.ring = 1'b1;
      if (k < MaskBits) begin
        r.timer_active_mask[k] = tmr_act[k];
        r.timer_done_mask[k]   = tmr_act[k] && tmr_done[k];
      end
    end
    for (int k = 0; k < NumAlarms; k++) begin
      if (alm_act[k] && alm_done[k]) r.ring = 1'b1;
      if (k < MaskBits) begin
        r.alarm_active_mask[k] = alm_act[k];
        r.alarm_done_mask[k]   = alm_act[k] && alm_done[k];
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // one input transfer after a random gap, prediction taken at acceptance
  task automatic send_item(in_item_t it);
    int gap;
    gap = in_idle_on ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(bank_step(it));
  endtask

  // drop valid and hold off until every expected result has come
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  // register write followed by a read back
  task automatic write_hold(logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ApbAddrW'(4 * HoldIdx);
    pwdata  <= {24'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    hold_model = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[7:0] != value) begin
      $error("hold_seconds: expected %0d, got %0d", value, prdata[7:0]);
      mismatch_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic do_set(action_e act, logic [6:0] h, logic [6:0] m, logic [6:0] s);
    in_item_t it;
    it             = '0;
    it.action      = act;
    it.set_hours   = h;
    it.set_minutes = m;
    it.set_seconds = s;
    send_item(it);
  endtask

  task automatic do_tick(logic [4:0] h, logic [5:0] m, logic [5:0] s);
    in_item_t it;
    it            = '0;
    it.action     = ACT_TICK;
    it.now_hour   = h;
    it.now_minute = m;
    it.now_second = s;
    send_item(it);
  endtask

  task automatic do_read(logic kind, logic [2:0] slot);
    in_item_t it;
    it             = '0;
    it.action      = ACT_READ;
    it.slot_kind   = kind;
    it.slot_number = slot;
    send_item(it);
  endtask

  // mostly well-formed traffic: ticks walk the clock, sets land on reachable
  // times; a few ticks carry random times and rare sets carry raw fields
  function automatic in_item_t random_item();
    in_item_t it;
    int       pick;
    int       t;
    it.action      = ACT_READ;
    it.set_hours   = 7'($urandom);
    it.set_minutes = 7'($urandom);
    it.set_seconds = 7'($urandom);
    it.now_hour    = 5'($urandom);
    it.now_minute  = 6'($urandom);
    it.now_second  = 6'($urandom);
    it.slot_kind   = 1'($urandom);
    it.slot_number = 3'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      it.action = ACT_TICK;
      if ($urandom_range(0, 99) >= 8) begin
        t     = (tod_h * 3600 + tod_m * 60 + tod_s + 1) % 86400;
        tod_h = t / 3600;
        tod_m = (t / 60) % 60;
        tod_s = t % 60;
        it.now_hour   = 5'(tod_h);
        it.now_minute = 6'(tod_m);
        it.now_second = 6'(tod_s);
      end
    end else if (pick < 65) begin
      it.action = ACT_SET_TIMER;
      if ($urandom_range(0, 299) != 0) begin
        it.set_hours   = 7'd0;
        it.set_minutes = ($urandom_range(0, 9) == 0) ? 7'd1 : 7'd0;
        it.set_seconds = 7'($urandom_range(0, 30));
      end
    end else if (pick < 80) begin
      it.action = ACT_SET_ALARM;
      if ($urandom_range(0, 299) != 0) begin
        t = (tod_h * 3600 + tod_m * 60 + tod_s + $urandom_range(1, 15)) % 86400;
        it.set_hours   = 7'(t / 3600);
        it.set_minutes = 7'((t / 60) % 60);
        it.set_seconds = 7'(t % 60);
      end
    end
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // result side: random stall and checking
  // ---------------------------------------------------------------------------

  initial begin
    int n;
    out_stall_i <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      n = out_idle_on ? $urandom_range(0, 19) : 0;
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin
    out_item_t want;
    out_item_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = out_data_o;
      if (pending_results.size() == 0) begin
        $error("result transfer with no result expected");
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("accepted", want.accepted, got.accepted);
        check_field("slot_used", want.slot_used, got.slot_used);
        check_field("ring", want.ring, got.ring);
        check_field("timer_done_mask", want.timer_done_mask, got.timer_done_mask);
        check_field("alarm_done_mask", want.alarm_done_mask, got.alarm_done_mask);
        check_field("timer_active_mask", want.timer_active_mask, got.timer_active_mask);
        check_field("alarm_active_mask", want.alarm_active_mask, got.alarm_active_mask);
        check_field("read_hours", want.read_hours, got.read_hours);
        check_field("read_minutes", want.read_minutes, got.read_minutes);
        check_field("read_seconds", want.read_seconds, got.read_seconds);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // empty bank: reads return zero, a tick changes nothing
  task automatic test_reset_state();
    do_read(1'b0, 3'd0);
    do_read(1'b1, 3'd4);
    do_tick(5'd0, 6'd0, 6'd0);
  endtask

  // fill both banks, saturate fields, overflow each bank
  task automatic test_fill_banks();
    do_set(ACT_SET_TIMER, 7'd0, 7'd0, 7'd0);
    do_set(ACT_SET_TIMER, 7'd0, 7'd0, 7'd127);
    do_set(ACT_SET_TIMER, 7'd0, 7'd1, 7'd0);
    do_set(ACT_SET_TIMER, 7'd1, 7'd0, 7'd0);
    do_set(ACT_SET_TIMER, 7'd0, 7'd0, 7'd2);
    do_set(ACT_SET_TIMER, 7'd0, 7'd0, 7'd5);
    do_set(ACT_SET_ALARM, 7'd0, 7'd0, 7'd1);
    do_set(ACT_SET_ALARM, 7'd127, 7'd127, 7'd127);
    do_set(ACT_SET_ALARM, 7'd0, 7'd0, 7'd1);
    do_set(ACT_SET_ALARM, 7'd0, 7'd0, 7'd1);
    do_set(ACT_SET_ALARM, 7'd0, 7'd0, 7'd1);
    do_set(ACT_SET_ALARM, 7'd23, 7'd59, 7'd59);
  endtask

  // first tick: zero timer and matching alarms ring, borrows show in reads
  task automatic test_countdown();
    do_tick(5'd0, 6'd0, 6'd1);
    do_read(1'b0, 3'd1);
    do_read(1'b0, 3'd3);
    do_read(1'b0, 3'd2);
    do_read(1'b0, 3'd7);
    do_read(1'b1, 3'd5);
  endtask

  // hold at both extremes, then lowered below the age of a ringing slot
  task automatic test_hold_register();
    wait_drained();
    write_hold(8'd0);
    do_tick(5'd31, 6'd63, 6'd63);
    wait_drained();
    write_hold(8'd255);
    do_set(ACT_SET_TIMER, 7'd0, 7'd0, 7'd0);
    do_tick(5'd0, 6'd0, 6'd2);
    do_tick(5'd0, 6'd0, 6'd3);
    do_tick(5'd0, 6'd0, 6'd4);
    wait_drained();
    write_hold(8'd1);
    do_tick(5'd0, 6'd0, 6'd5);
  endtask

  task automatic test_random_traffic();
    logic [7:0] hold_plan [7];
    hold_plan = '{8'd0, 8'd255, 8'd3, 8'd1, 8'd20, 8'($urandom), 8'd7};
    for (int p = 0; p < 7; p++) begin
      wait_drained();
      write_hold(hold_plan[p]);
      for (int n = 0; n < 205; n++) begin
        // idling pattern changes every fifty items, including none at all
        if (n % 50 == 0) begin
          case ($urandom_range(0, 3))
            0: begin in_idle_on = 1'b0; out_idle_on = 1'b0; end
            1: begin in_idle_on = 1'b1; out_idle_on = 1'b1; end
            2: begin in_idle_on = 1'b1; out_idle_on = 1'b0; end
            default: begin in_idle_on = 1'b0; out_idle_on = 1'b1; end
          endcase
        end
        if (n == 100) wait_drained();
        send_item(random_item());
      end
    end
  endtask

  initial begin
    in_valid_i <= 1'b0;
    in_data_i  <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_fill_banks();
    test_countdown();
    test_hold_register();
    test_random_traffic();
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("tb_countdown_timer_alarm_bank passed");
    end else begin
      $display("tb_countdown_timer_alarm_bank failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("tb_countdown_timer_alarm_bank failed");
    $finish;
  end

endmodule
